/* hdl/tcpt_pkg.sv */
// Package with shared types, constants and the arctangent table for the curve block.
`timescale 1ns / 1ps
`default_nettype none

package tcpt_pkg;

    // Number of axes that the block evaluates side by side.
    localparam int NUM_AXES = 3;

    // Register indexes on the configuration port (paddr[4:3]).
    localparam logic [1:0] REG_AXIS_X = 2'd0;
    localparam logic [1:0] REG_AXIS_Y = 2'd1;
    localparam logic [1:0] REG_AXIS_Z = 2'd2;

    // CORDIC start value: the inverse gain 0.60725293 in Q2.30.
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Two pi in Q4.28.
    localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;

    // One axis register, laid out as it is written on the bus.
    typedef struct packed {
        logic        [15:0] freq;
        logic        [15:0] phase;
        logic signed [15:0] mag;
        logic signed [15:0] offset;
    } t_axis_cfg;

    typedef t_axis_cfg [NUM_AXES-1:0] t_cfg_set;

    // Rotation state carried from cell to cell for one axis.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               neg;
    } t_rot;

    typedef t_rot [NUM_AXES-1:0] t_rot_set;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tcpt_angle.sv */
// Angle front end: forms the wrapped turn angle per axis and the CORDIC start state.
`timescale 1ns / 1ps
`default_nettype none

module tcpt_angle
    import tcpt_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg_set    i_cfg,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_param_u,
    output logic             o_ready,
    output logic             o_valid,
    output t_rot_set         o_rot,
    input  wire logic        i_ready
);

    logic                r_v0;
    logic                r_v1;
    logic [23:0]         r_prod [NUM_AXES];
    t_rot_set            r_rot;
    logic                w_rdy0;
    logic                w_rdy1;
    t_rot_set            n_rot;

    // A stage takes new data when it is empty or its successor moves.
    assign w_rdy1  = !r_v1 || i_ready;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r_v1;
    assign o_rot   = r_rot;

    // Phase add, truncation to the angle resolution and half-turn range reduction.
    always_comb begin
        logic [23:0] t24;
        logic [31:0] a;
        logic        neg;
        for (int k = 0; k < NUM_AXES; k++) begin
            t24 = r_prod[k] + {i_cfg[k].phase, 8'd0};
            a   = {t24[23 -: ANGLE_BITS], {(32 - ANGLE_BITS){1'b0}}};
            neg = a[31] ^ a[30];
            n_rot[k].x   = CORDIC_GAIN_Q30;
            n_rot[k].y   = 32'sd0;
            n_rot[k].z   = $signed({a[31] ^ neg, a[30:0]});
            n_rot[k].neg = neg;
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    // Payload: only the low 24 bits of freq*u matter, the angle wraps at one turn.
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prod[k] <= 24'(i_cfg[k].freq * i_param_u);
            end
        end
        if (w_rdy1) begin
            r_rot <= n_rot;
        end
    end

endmodule

`default_nettype wire

/* hdl/tcpt_cordic_cell.sv */
// One CORDIC rotation cell, working on all three axes in parallel lanes.
`timescale 1ns / 1ps
`default_nettype none

module tcpt_cordic_cell
    import tcpt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_rot_set i_rot,
    output logic          o_ready,
    output logic          o_valid,
    output t_rot_set      o_rot,
    input  wire logic     i_ready
);

    localparam logic signed [31:0] Atan = $signed(atan_turn(IDX));

    logic     r_valid;
    t_rot_set r_rot;
    t_rot_set n_rot;
    logic     w_rdy;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    // Rotate toward zero residual angle; shifts round toward minus infinity.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_rot[k].neg = i_rot[k].neg;
            if (!i_rot[k].z[31]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> IDX);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> IDX);
                n_rot[k].z = i_rot[k].z - Atan;
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> IDX);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> IDX);
                n_rot[k].z = i_rot[k].z + Atan;
            end
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_rot <= n_rot;
        end
    end

endmodule

`default_nettype wire

/* hdl/tcpt_post.sv */
// Back end: scales sine and cosine into position and path derivative per axis.
`timescale 1ns / 1ps
`default_nettype none

module tcpt_post
    import tcpt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg_set i_cfg,
    input  wire logic     i_valid,
    input  wire t_rot_set i_rot,
    output logic          o_ready,
    output logic          o_valid,
    output logic [191:0]  o_data,
    input  wire logic     i_ready
);

    localparam int NumStages = 5;

    logic [NumStages-1:0] r_v;
    logic [NumStages-1:0] w_rdy;

    // Stage 0: sign-corrected cosine and sine, freq*mag.
    logic signed [32:0] r_c   [NUM_AXES];
    logic signed [32:0] r_s   [NUM_AXES];
    logic signed [32:0] r_fm  [NUM_AXES];
    // Stage 1: products.
    logic signed [48:0] r_pm  [NUM_AXES];
    logic signed [65:0] r_vm  [NUM_AXES];
    // Stage 2: rounded position and first rounding of the derivative.
    logic signed [31:0] r_pos2 [NUM_AXES];
    logic signed [33:0] r_t1   [NUM_AXES];
    // Stage 3: scaling by two pi.
    logic signed [31:0] r_pos3 [NUM_AXES];
    logic signed [65:0] r_t1p  [NUM_AXES];
    // Stage 4: output register.
    logic signed [31:0] r_pos4 [NUM_AXES];
    logic signed [31:0] r_vel4 [NUM_AXES];

    // Ready chain from the output back to the input.
    always_comb begin
        w_rdy[NumStages-1] = !r_v[NumStages-1] || i_ready;
        for (int i = NumStages - 2; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NumStages-1];
    assign o_data  = {r_vel4[2], r_vel4[1], r_vel4[0], r_pos4[2], r_pos4[1], r_pos4[0]};

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NumStages; i++) begin
                if (w_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // User keeps register values fixed while items are in flight; unchecked.
    always_ff @(posedge i_clk) begin
        logic signed [48:0] p;
        logic signed [65:0] t1;
        logic signed [65:0] t2;
        for (int k = 0; k < NUM_AXES; k++) begin
            if (w_rdy[0]) begin
                r_c[k]  <= i_rot[k].neg ? -33'(i_rot[k].x) : 33'(i_rot[k].x);
                r_s[k]  <= i_rot[k].neg ? -33'(i_rot[k].y) : 33'(i_rot[k].y);
                r_fm[k] <= $signed({1'b0, i_cfg[k].freq}) * i_cfg[k].mag;
            end
            if (w_rdy[1]) begin
                r_pm[k] <= i_cfg[k].mag * r_c[k];
                r_vm[k] <= r_fm[k] * r_s[k];
            end
            if (w_rdy[2]) begin
                p = ((r_pm[k] + 49'sd2097152) >>> 22) + $signed({i_cfg[k].offset, 8'd0});
                r_pos2[k] <= sat32(68'(p));
                t1 = (r_vm[k] + 66'sd536870912) >>> 30;
                r_t1[k] <= t1[33:0];
            end
            if (w_rdy[3]) begin
                r_pos3[k] <= r_pos2[k];
                r_t1p[k]  <= r_t1[k] * TWO_PI_Q28;
            end
            if (w_rdy[4]) begin
                r_pos4[k] <= r_pos3[k];
                t2 = (r_t1p[k] + 66'sd134217728) >>> 28;
                r_vel4[k] <= sat32(-68'(t2));
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/trig_curve_point_and_tangent.sv */
// Top level of the 3D Lissajous curve point and path derivative generator.
//
// Usage:
//   Curve parameters u (Q1.16, 65536 = one) enter on the s_axis stream; each
//   request yields one result on the m_axis stream with the x, y and z
//   positions and path derivatives, all signed Q16.16 and saturated.
//   Three 64-bit axis registers are written over the APB-style port at byte
//   addresses 0, 8 and 16; write them only while no request is in flight.
//   The chain holds two angle stages, one CORDIC cell per rotation step
//   and five scaling stages. While the receiver does not stall, the chain
//   accepts one request every cycle and sustains one result per cycle.
//   Every stage holds its own valid flag, so when the receiver stalls the
//   chain keeps filling empty stages and drops s_axis_tready only once all
//   SINE_STAGES + 7 stages hold a request. Nothing is lost or repeated.
//   A synchronous reset empties the chain and clears all three axis
//   registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module trig_curve_point_and_tangent
    import tcpt_pkg::*;
#(
    parameter int ANGLE_BITS  = 16,
    parameter int SINE_STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // [16:0] param_u, [23:17] zero
    // Output stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    t_cfg_set               r_cfg;
    logic [SINE_STAGES:0]   w_vld;
    logic [SINE_STAGES:0]   w_rdy;
    t_rot_set               w_rot [SINE_STAGES+1];
    logic                   w_post_rdy;

    // Register write on the access cycle; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:3])
                REG_AXIS_X: r_cfg[0] <= t_axis_cfg'(pwdata);
                REG_AXIS_Y: r_cfg[1] <= t_axis_cfg'(pwdata);
                REG_AXIS_Z: r_cfg[2] <= t_axis_cfg'(pwdata);
                default: ;
            endcase
        end
    end

    // Register read.
    always_comb begin
        unique case (paddr[4:3])
            REG_AXIS_X: prdata = r_cfg[0];
            REG_AXIS_Y: prdata = r_cfg[1];
            REG_AXIS_Z: prdata = r_cfg[2];
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Angle front end.
    tcpt_angle #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_angle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .i_param_u (s_axis_tdata[16:0]),
        .o_ready   (s_axis_tready),
        .o_valid   (w_vld[0]),
        .o_rot     (w_rot[0]),
        .i_ready   (w_rdy[0])
    );

    // Chain of CORDIC cells, one rotation step each.
    for (genvar g = 0; g < SINE_STAGES; g++) begin : g_cell
        tcpt_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_rot   (w_rot[g]),
            .o_ready (w_rdy[g]),
            .o_valid (w_vld[g+1]),
            .o_rot   (w_rot[g+1]),
            .i_ready (w_rdy[g+1])
        );
    end

    assign w_rdy[SINE_STAGES] = w_post_rdy;

    // Scaling back end and output register.
    tcpt_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_vld[SINE_STAGES]),
        .i_rot   (w_rot[SINE_STAGES]),
        .o_ready (w_post_rdy),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

endmodule

`default_nettype wire

/* hdl/tcpt_checker.sv */
// Port-level assertions for the curve block and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module tcpt_checker
    import tcpt_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [191:0] m_axis_tdata,
    input wire logic         psel,
    input wire logic         penable,
    input wire logic         pwrite,
    input wire logic [4:0]   paddr,
    input wire logic [63:0]  pwdata,
    input wire logic [63:0]  prdata,
    input wire logic         pready
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A ready receiver lets the whole chain move, so input is taken.
    a_flow_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled although output is ready");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // The X axis register reads back what was written to it.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[4:3] == REG_AXIS_X)
        |=> (paddr[4:3] != REG_AXIS_X || prdata == $past(pwdata)))
        else $error("register readback mismatch");

endmodule

bind trig_curve_point_and_tangent tcpt_checker u_tcpt_checker (.*);

`default_nettype wire
